FILE: design/look_at_view_matrix_defines.svh
// Assertion macros shared by the look-at view matrix design.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LAVM_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LAVM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lavm_pkg.sv
// Package: widths, types and helper functions of the look-at view matrix.
`timescale 1ns / 1ps
package lavm_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC      = 16;
  localparam int SCALE_W   = 30;                  // prescaled magnitudes lie below 2^SCALE_W
  localparam int VEC_W     = COORD_W + FRAC;      // widest vector normalized
  localparam int POS_W     = 6;
  localparam int SQ_W      = 2 * SCALE_W + 2;     // sum of three squares
  localparam int SQ_STEPS  = SCALE_W + 1;         // one result bit per stage
  localparam int LEN_W     = SCALE_W + 1;
  localparam int UNIT_W    = FRAC + 2;            // unit components, magnitude up to 1.0
  localparam int AXIS_W    = FRAC + 4;
  localparam int AUX_W     = SCALE_W + 1;
  localparam int DIV_STEPS = FRAC + 1;
  localparam int HALF      = 1 << (FRAC - 1);

  localparam logic [1:0] ROW_LAST = 2'd3;
  localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(64'd1 << FRAC);

  typedef struct packed {
    logic [2:0][COORD_W-1:0] eye;
    logic [2:0][AUX_W-1:0]   aux;
    logic                    degen;
  } side_t;

  function automatic logic [VEC_W-1:0] mag_of(input logic [VEC_W-1:0] v);
    return v[VEC_W-1] ? (~v + VEC_W'(1)) : v;
  endfunction

  function automatic logic [POS_W-1:0] msb_pos(input logic [VEC_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // Shift so that a magnitude with its top bit at p lands in [2^29, 2^30).
  function automatic logic [SCALE_W-1:0] scale_mag(input logic [VEC_W-1:0] m,
                                                   input logic [POS_W-1:0] p);
    logic [VEC_W-1:0] t;
    if (p >= POS_W'(SCALE_W - 1)) begin
      t = m >> (p - POS_W'(SCALE_W - 1));
    end else begin
      t = m << (POS_W'(SCALE_W - 1) - p);
    end
    return t[SCALE_W-1:0];
  endfunction

endpackage

FILE: design/lavm_if.sv
// Interfaces: input channel and result channel of the look-at view matrix.
`timescale 1ns / 1ps
interface lavm_in_if;
  import lavm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] eye_x;
  logic [COORD_W-1:0] eye_y;
  logic [COORD_W-1:0] eye_z;
  logic [COORD_W-1:0] target_x;
  logic [COORD_W-1:0] target_y;
  logic [COORD_W-1:0] target_z;
  logic [COORD_W-1:0] up_x;
  logic [COORD_W-1:0] up_y;
  logic [COORD_W-1:0] up_z;
  modport source(output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                 up_x, up_y, up_z, input ready);
  modport sink(input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               up_x, up_y, up_z, output ready);
endinterface

interface lavm_out_if;
  import lavm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         row;
  logic [COORD_W-1:0] col0;
  logic [COORD_W-1:0] col1;
  logic [COORD_W-1:0] col2;
  logic [COORD_W-1:0] col3;
  logic               last;
  logic               degenerate;
  modport source(output valid, row, col0, col1, col2, col3, last, degenerate, input ready);
  modport sink(input valid, row, col0, col1, col2, col3, last, degenerate, output ready);
endinterface

FILE: design/lavm_norm.sv
// Pipelined normalizer: prescale, sum of squares, square root, three dividers.
`timescale 1ns / 1ps
module lavm_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               in_valid,
  input  logic [2:0][lavm_pkg::VEC_W-1:0]    in_vec,
  input  lavm_pkg::side_t                    in_side,
  output logic                               out_valid,
  output logic [2:0][lavm_pkg::UNIT_W-1:0]   out_unit,
  output logic                               out_nz,
  output lavm_pkg::side_t                    out_side
);
  import lavm_pkg::*;

  typedef struct packed {
    side_t                   side;
    logic [2:0]              sgn;
    logic                    nz;
    logic [2:0][SCALE_W-1:0] sm;
  } hdr_t;

  typedef struct packed {
    hdr_t            h;
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqs_t;

  typedef struct packed {
    side_t                     side;
    logic [2:0]                sgn;
    logic                      nz;
    logic [LEN_W-1:0]          len;
    logic [2:0][VEC_W-1:0]     rem;
    logic [2:0][DIV_STEPS-1:0] q;
  } dvs_t;

  // magnitudes and leading one
  logic [2:0][VEC_W-1:0] mag_a;
  logic [VEC_W-1:0]      any_a;
  logic                  a_v_r;
  side_t                 a_side_r;
  logic [2:0]            a_sgn_r;
  logic [2:0][VEC_W-1:0] a_mag_r;
  logic [POS_W-1:0]      a_pos_r;
  logic                  a_nz_r;

  always_comb begin
    any_a = '0;
    for (int i = 0; i < 3; i++) begin
      mag_a[i] = mag_of(in_vec[i]);
      any_a    = any_a | mag_a[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= in_side;
      for (int i = 0; i < 3; i++) a_sgn_r[i] <= in_vec[i][VEC_W-1];
      a_mag_r  <= mag_a;
      a_pos_r  <= msb_pos(any_a);
      a_nz_r   <= |any_a;
    end
  end

  // prescale shift
  logic b_v_r;
  hdr_t b_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_h_r.side <= a_side_r;
      b_h_r.sgn  <= a_sgn_r;
      b_h_r.nz   <= a_nz_r;
      for (int i = 0; i < 3; i++) b_h_r.sm[i] <= scale_mag(a_mag_r[i], a_pos_r);
    end
  end

  // squares
  logic                        c_v_r;
  hdr_t                        c_h_r;
  logic [2:0][2*SCALE_W-1:0]   c_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_h_r <= b_h_r;
      for (int i = 0; i < 3; i++) c_sq_r[i] <= b_h_r.sm[i] * b_h_r.sm[i];
    end
  end

  // square root, one result bit per stage
  logic sq_v_r [0:SQ_STEPS];
  sqs_t sq_r   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].h <= c_h_r;
      sq_r[0].n <= SQ_W'(c_sq_r[0]) + SQ_W'(c_sq_r[1]) + SQ_W'(c_sq_r[2]);
      sq_r[0].r <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    sqs_t            step_nxt;

    always_comb begin
      step_nxt = sq_r[k];
      trial    = sq_r[k].r + BIT;
      if (sq_r[k].n >= trial) begin
        step_nxt.n = sq_r[k].n - trial;
        step_nxt.r = (sq_r[k].r >> 1) + BIT;
      end else begin
        step_nxt.r = sq_r[k].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= step_nxt;
      end
    end
  end

  // dividers: rounded numerator, then one quotient bit per stage
  logic dv_v_r [0:DIV_STEPS];
  dvs_t dv_r   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].side <= sq_r[SQ_STEPS].h.side;
      dv_r[0].sgn  <= sq_r[SQ_STEPS].h.sgn;
      dv_r[0].nz   <= sq_r[SQ_STEPS].h.nz;
      dv_r[0].len  <= sq_r[SQ_STEPS].r[LEN_W-1:0];
      dv_r[0].q    <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= (VEC_W'(sq_r[SQ_STEPS].h.sm[i]) << FRAC)
                        + VEC_W'(sq_r[SQ_STEPS].r[LEN_W-1:1]);
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - k;
    logic [VEC_W-1:0] dsor;
    dvs_t             step_nxt;

    always_comb begin
      step_nxt = dv_r[k];
      dsor     = VEC_W'(dv_r[k].len) << SH;
      for (int i = 0; i < 3; i++) begin
        if (dv_r[k].rem[i] >= dsor) begin
          step_nxt.rem[i]   = dv_r[k].rem[i] - dsor;
          step_nxt.q[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1] <= step_nxt;
      end
    end
  end

  // sign back on, zero vector gives zero axis
  logic                     o_v_r;
  logic [2:0][UNIT_W-1:0]   o_unit_r;
  logic                     o_nz_r;
  side_t                    o_side_r;
  logic [2:0][UNIT_W-1:0]   unit_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_nxt[i] = {1'b0, dv_r[DIV_STEPS].q[i]};
      if (dv_r[DIV_STEPS].sgn[i]) unit_nxt[i] = ~unit_nxt[i] + UNIT_W'(1);
      if (!dv_r[DIV_STEPS].nz) unit_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_unit_r <= unit_nxt;
      o_nz_r   <= dv_r[DIV_STEPS].nz;
      o_side_r <= dv_r[DIV_STEPS].side;
    end
  end

  assign out_valid = o_v_r;
  assign out_unit  = o_unit_r;
  assign out_nz    = o_nz_r;
  assign out_side  = o_side_r;

endmodule

FILE: design/look_at_view_matrix.sv
// Top level: left-handed look-at view matrix in signed Q16.16, fully pipelined.
`timescale 1ns / 1ps
// Usage:
//   in_ch  - one transfer carries eye, target and world-up hint (signed Q16.16).
//   out_ch - four transfers per input, rows 0 to 3 in order; last marks row 3.
//            Rows 0..2 hold (right, camera up, forward, 0); row 3 holds the
//            saturated translation terms and 1.0. degenerate is the same on all
//            four rows and flags a zero-length vector before a normalization.
// Row order: after row 0 is presented, rows 1..3 follow one per cycle while
//   out_ch.ready stays high.
// Intake: an input is taken only while the output register is free or its last
//   row leaves. Every pipeline stage moves by one whole-pipe advance, so items
//   may enter back to back until that register fills; the pipeline fills behind it.
// Stalls: while the receiver holds ready low the output register keeps its row
//   and the whole pipeline holds; in_ch.ready drops, nothing is lost or repeated.
// Reset: synchronous active-low rst_n clears every valid bit and the row
//   counter; the pipeline comes up empty and ready.
// Datapath: two normalizers (square root one bit per stage, three restoring
//   dividers one quotient bit per stage), cross products, dot products.
module look_at_view_matrix (
  input  logic      clk,
  input  logic      rst_n,
  lavm_in_if.sink   in_ch,
  lavm_out_if.source out_ch
);
  import lavm_pkg::*;

`include "look_at_view_matrix_defines.svh"

  localparam int AX_R   = 0;
  localparam int AX_U   = 1;
  localparam int AX_F   = 2;
  localparam int XP_W   = AUX_W + UNIT_W;        // up hint times forward
  localparam int UP_W   = 2 * UNIT_W;            // forward times right
  localparam int DIFF_W = UP_W + 2;
  localparam int PROD_W = AXIS_W + COORD_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int RND_W  = DOT_W - FRAC;

  // Negate a rounded dot product and clamp it to the coordinate range.
  function automatic logic [COORD_W-1:0] neg_sat(input logic [RND_W-1:0] x);
    logic [RND_W:0] n;
    n = ~{x[RND_W-1], x} + (RND_W + 1)'(1);
    if ((&n[RND_W:COORD_W-1]) || !(|n[RND_W:COORD_W-1])) begin
      return n[COORD_W-1:0];
    end
    return n[RND_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  // One advance signal moves the whole pipe: free output register, or its
  // last row leaving in this cycle.
  logic adv;
  logic mat_v_r;
  logic [1:0] row_r;

  assign adv         = !mat_v_r || (out_ch.ready && row_r == ROW_LAST);
  assign in_ch.ready = adv;

  // ---- stage s1: register inputs, form target - eye, find up hint's leading one
  logic [2:0][COORD_W-1:0] eye_in, tgt_in, up_in;
  logic [2:0][VEC_W-1:0]   umag_in;
  logic [VEC_W-1:0]        uany_in;

  always_comb begin
    eye_in  = {in_ch.eye_z, in_ch.eye_y, in_ch.eye_x};
    tgt_in  = {in_ch.target_z, in_ch.target_y, in_ch.target_x};
    up_in   = {in_ch.up_z, in_ch.up_y, in_ch.up_x};
    uany_in = '0;
    for (int i = 0; i < 3; i++) begin
      umag_in[i] = mag_of(VEC_W'($signed(up_in[i])));
      uany_in    = uany_in | umag_in[i];
    end
  end

  logic                    s1_v_r;
  logic [2:0][COORD_W-1:0] s1_eye_r;
  logic [2:0][VEC_W-1:0]   s1_d_r;
  logic [2:0]              s1_usgn_r;
  logic [2:0][VEC_W-1:0]   s1_umag_r;
  logic [POS_W-1:0]        s1_upos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_eye_r  <= eye_in;
      s1_umag_r <= umag_in;
      s1_upos_r <= msb_pos(uany_in);
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i]    <= VEC_W'($signed(tgt_in[i])) - VEC_W'($signed(eye_in[i]));
        s1_usgn_r[i] <= up_in[i][COORD_W-1];
      end
    end
  end

  // ---- stage s2: prescaled up hint rides along as side data
  logic                  s2_v_r;
  logic [2:0][VEC_W-1:0] s2_vec_r;
  side_t                 s2_side_r;
  logic [2:0][AUX_W-1:0] ups_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ups_nxt[i] = AUX_W'(scale_mag(s1_umag_r[i], s1_upos_r));
      if (s1_usgn_r[i]) ups_nxt[i] = ~ups_nxt[i] + AUX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_vec_r        <= s1_d_r;
      s2_side_r.eye   <= s1_eye_r;
      s2_side_r.aux   <= ups_nxt;
      s2_side_r.degen <= 1'b0;
    end
  end

  // ---- forward axis
  logic                   n1_v, n1_nz;
  logic [2:0][UNIT_W-1:0] n1_f;
  side_t                  n1_side;

  lavm_norm u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s2_v_r),
    .in_vec    (s2_vec_r),
    .in_side   (s2_side_r),
    .out_valid (n1_v),
    .out_unit  (n1_f),
    .out_nz    (n1_nz),
    .out_side  (n1_side)
  );

  // ---- stages x1, x2: up hint x forward
  logic signed [AUX_W-1:0]  ua [3];
  logic signed [UNIT_W-1:0] fa [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ua[i] = $signed(n1_side.aux[i]);
      fa[i] = $signed(n1_f[i]);
    end
  end

  logic                    x1_v_r;
  logic [5:0][XP_W-1:0]    x1_prod_r;
  logic [2:0][COORD_W-1:0] x1_eye_r;
  logic [2:0][UNIT_W-1:0]  x1_f_r;
  logic                    x1_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
    end else if (adv) begin
      x1_v_r <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_prod_r[0] <= ua[1] * fa[2];
      x1_prod_r[1] <= ua[2] * fa[1];
      x1_prod_r[2] <= ua[2] * fa[0];
      x1_prod_r[3] <= ua[0] * fa[2];
      x1_prod_r[4] <= ua[0] * fa[1];
      x1_prod_r[5] <= ua[1] * fa[0];
      x1_eye_r     <= n1_side.eye;
      x1_f_r       <= n1_f;
      x1_degen_r   <= !n1_nz;
    end
  end

  logic                  x2_v_r;
  logic [2:0][VEC_W-1:0] x2_vec_r;
  side_t                 x2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x2_v_r <= 1'b0;
    end else if (adv) begin
      x2_v_r <= x1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        x2_vec_r[i]      <= VEC_W'($signed(x1_prod_r[2*i]))
                          - VEC_W'($signed(x1_prod_r[2*i+1]));
        x2_side_r.aux[i] <= AUX_W'($signed(x1_f_r[i]));
      end
      x2_side_r.eye   <= x1_eye_r;
      x2_side_r.degen <= x1_degen_r;
    end
  end

  // ---- right axis; forward travels in the side data
  logic                   n2_v, n2_nz;
  logic [2:0][UNIT_W-1:0] n2_r;
  side_t                  n2_side;

  lavm_norm u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (x2_v_r),
    .in_vec    (x2_vec_r),
    .in_side   (x2_side_r),
    .out_valid (n2_v),
    .out_unit  (n2_r),
    .out_nz    (n2_nz),
    .out_side  (n2_side)
  );

  // ---- stages u1, u2: camera up = forward x right, rounded half up
  logic signed [UNIT_W-1:0] fb [3];
  logic signed [UNIT_W-1:0] rb [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fb[i] = $signed(n2_side.aux[i][UNIT_W-1:0]);
      rb[i] = $signed(n2_r[i]);
    end
  end

  logic                    u1_v_r;
  logic [5:0][UP_W-1:0]    u1_prod_r;
  logic [2:0][UNIT_W-1:0]  u1_r_r, u1_f_r;
  logic [2:0][COORD_W-1:0] u1_eye_r;
  logic                    u1_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_v_r <= 1'b0;
    end else if (adv) begin
      u1_v_r <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_prod_r[0] <= fb[1] * rb[2];
      u1_prod_r[1] <= fb[2] * rb[1];
      u1_prod_r[2] <= fb[2] * rb[0];
      u1_prod_r[3] <= fb[0] * rb[2];
      u1_prod_r[4] <= fb[0] * rb[1];
      u1_prod_r[5] <= fb[1] * rb[0];
      u1_r_r       <= n2_r;
      for (int i = 0; i < 3; i++) u1_f_r[i] <= n2_side.aux[i][UNIT_W-1:0];
      u1_eye_r     <= n2_side.eye;
      u1_degen_r   <= n2_side.degen || !n2_nz;
    end
  end

  logic signed [DIFF_W-1:0] usum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      usum[i] = DIFF_W'($signed(u1_prod_r[2*i])) - DIFF_W'($signed(u1_prod_r[2*i+1]))
              + DIFF_W'(HALF);
    end
  end

  logic                        u2_v_r;
  logic [2:0][2:0][AXIS_W-1:0] u2_ax_r;
  logic [2:0][COORD_W-1:0]     u2_eye_r;
  logic                        u2_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u2_v_r <= 1'b0;
    end else if (adv) begin
      u2_v_r <= u1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u2_ax_r[AX_R][i] <= AXIS_W'($signed(u1_r_r[i]));
        u2_ax_r[AX_U][i] <= AXIS_W'(usum[i] >>> FRAC);
        u2_ax_r[AX_F][i] <= AXIS_W'($signed(u1_f_r[i]));
      end
      u2_eye_r   <= u1_eye_r;
      u2_degen_r <= u1_degen_r;
    end
  end

  // ---- stages t1, t2: exact dot products with the eye, rounded once
  logic signed [AXIS_W-1:0]  axs [3][3];
  logic signed [COORD_W-1:0] eys [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      eys[a] = $signed(u2_eye_r[a]);
      for (int i = 0; i < 3; i++) axs[a][i] = $signed(u2_ax_r[a][i]);
    end
  end

  logic                        t1_v_r;
  logic [2:0][2:0][PROD_W-1:0] t1_prod_r;
  logic [2:0][2:0][AXIS_W-1:0] t1_ax_r;
  logic                        t1_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (adv) begin
      t1_v_r <= u2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) t1_prod_r[a][i] <= axs[a][i] * eys[i];
      end
      t1_ax_r    <= u2_ax_r;
      t1_degen_r <= u2_degen_r;
    end
  end

  logic signed [DOT_W-1:0] dsum [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dsum[a] = DOT_W'($signed(t1_prod_r[a][0])) + DOT_W'($signed(t1_prod_r[a][1]))
              + DOT_W'($signed(t1_prod_r[a][2])) + DOT_W'(HALF);
    end
  end

  logic                        t2_v_r;
  logic [2:0][RND_W-1:0]       t2_dot_r;
  logic [2:0][2:0][AXIS_W-1:0] t2_ax_r;
  logic                        t2_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (adv) begin
      t2_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) t2_dot_r[a] <= RND_W'(dsum[a] >>> FRAC);
      t2_ax_r    <= t1_ax_r;
      t2_degen_r <= t1_degen_r;
    end
  end

  // ---- output register: one matrix, emitted a row per transfer
  logic [2:0][2:0][AXIS_W-1:0] mat_ax_r;
  logic [2:0][COORD_W-1:0]     mat_t_r;
  logic                        mat_degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_v_r <= 1'b0;
      row_r   <= '0;
    end else if (adv) begin
      mat_v_r <= t2_v_r;
      row_r   <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_ax_r    <= t2_ax_r;
      mat_degen_r <= t2_degen_r;
      for (int a = 0; a < 3; a++) mat_t_r[a] <= neg_sat(t2_dot_r[a]);
    end
  end

  always_comb begin
    if (row_r == ROW_LAST) begin
      out_ch.col0 = mat_t_r[AX_R];
      out_ch.col1 = mat_t_r[AX_U];
      out_ch.col2 = mat_t_r[AX_F];
      out_ch.col3 = ONE_Q;
    end else begin
      out_ch.col0 = COORD_W'($signed(mat_ax_r[AX_R][row_r]));
      out_ch.col1 = COORD_W'($signed(mat_ax_r[AX_U][row_r]));
      out_ch.col2 = COORD_W'($signed(mat_ax_r[AX_F][row_r]));
      out_ch.col3 = '0;
    end
  end

  assign out_ch.valid      = mat_v_r;
  assign out_ch.row        = row_r;
  assign out_ch.last       = (row_r == ROW_LAST);
  assign out_ch.degenerate = mat_degen_r;

  // ---- checks
  `LAVM_ASSERT_NEXT(a_row_step, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last, out_ch.valid && out_ch.row == $past(out_ch.row) + 2'd1, "row did not advance after a transfer")
  `LAVM_ASSERT_NEXT(a_degen_hold, clk, rst_n, out_ch.valid && !out_ch.last, out_ch.degenerate == $past(out_ch.degenerate), "degenerate changed within a matrix")
  `LAVM_ASSERT_SAME(a_last_row, clk, rst_n, out_ch.valid && out_ch.last, out_ch.row == ROW_LAST && out_ch.col3 == ONE_Q, "last row lacks index three or unit corner")
  `LAVM_ASSERT_SAME(a_take_free, clk, rst_n, in_ch.ready, !out_ch.valid || (out_ch.last && out_ch.ready), "pipe advanced over a waiting row")

endmodule
